// ===== src/swp_pkg.sv =====
// Shared types and constants of the swipe gesture detector.
// No dependencies; every other file imports this package.
`default_nettype none

package swp_pkg;

  localparam int KIND_W = 2;
  localparam int FING_W = 3;
  localparam int DIR_W  = 2;
  localparam int THR_W  = 20;
  localparam int CD_W   = 16;
  localparam int CFG_W  = 20;
  localparam int CFGI_W = 2;
  localparam int MS_W   = 32;

  localparam logic [KIND_W-1:0] KIND_BEGIN  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd3;

  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd0;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_UP    = 2'd3;

  localparam logic [CFGI_W-1:0] CFG_MAX_THR  = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_MIN_THR  = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_COOLDOWN = 2'd2;

  localparam logic [THR_W-1:0] MAX_THR_RST  = 20'd1600;
  localparam logic [THR_W-1:0] MIN_THR_RST  = 20'd480;
  localparam logic [CD_W-1:0]  COOLDOWN_RST = 16'd300;

  // status of the square root unit
  typedef struct packed {
    logic busy;
    logic done;
  } root_stat_t;

endpackage

`default_nettype wire

// ===== src/swp_if.sv =====
// Valid/ready channel interfaces for swipe events and gesture results.
// Depends on swp_pkg.
`default_nettype none

interface swp_in_if import swp_pkg::*; #(parameter int DELTA_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic        [KIND_W-1:0]      kind;
  logic signed [DELTA_WIDTH-1:0] delta_x;
  logic signed [DELTA_WIDTH-1:0] delta_y;
  logic        [FING_W-1:0]      finger_count;

  modport source (output valid, kind, delta_x, delta_y, finger_count, input ready);
  modport sink   (input valid, kind, delta_x, delta_y, finger_count, output ready);
endinterface

interface swp_out_if import swp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DIR_W-1:0]  direction;
  logic [FING_W-1:0] fingers;

  modport source (output valid, direction, fingers, input ready);
  modport sink   (input valid, direction, fingers, output ready);
endinterface

`default_nettype wire

// ===== src/swp_root_unit.sv =====
// Iterative integer square root, one result bit per cycle.
// Depends on swp_pkg for the status struct.
`default_nettype none

module swp_root_unit import swp_pkg::*; #(
  parameter int VW = 32
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [VW-1:0]   value,
  output root_stat_t           stat,
  output logic      [VW/2-1:0] root
);

  localparam int STEPS = VW / 2;
  localparam int CW    = $clog2(STEPS + 1);

  logic [VW-1:0] rem_r, rem_nxt;
  logic [VW-1:0] root_r, root_nxt;
  logic [VW-1:0] bit_r, bit_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [VW-1:0] trial;

  assign trial = root_r + bit_r;

  always_comb begin
    rem_nxt  = rem_r;
    root_nxt = root_r;
    bit_nxt  = bit_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = value;
      root_nxt = '0;
      bit_nxt  = {2'b01, {(VW-2){1'b0}}};
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_r >= trial) begin
        rem_nxt  = rem_r - trial;
        root_nxt = (root_r >> 1) + bit_r;
      end else begin
        root_nxt = root_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    bit_r  <= bit_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign root      = root_r[VW/2-1:0];

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !start) else $error("root unit restarted while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("root done without a run");
  a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("root unit still busy at done");

endmodule

`default_nettype wire

// ===== src/swipe_gesture_detector_unit.sv =====
// Top level of the swipe gesture detector: event channel, result channel,
// configuration port. Depends on swp_pkg, swp_if and swp_root_unit.
`default_nettype none

// Swipe gesture detector. Events arrive as beats on in_ch: begin clears the
// running X/Y sums, end is ignored, a tick ages the trigger timer, and an
// update adds its deltas to the saturating sums and tests for a swipe. A
// begin, end or tick beat is taken in the idle state, which stays ready for
// the next beat. An update beat keeps the block busy through its steps: one
// MW x MW multiplier (24x24 at the default widths) is shared for the five
// squares (delta x, delta y, threshold, sum x, sum y), and the speed root
// comes from a restoring square root that resolves one bit per cycle.
// The threshold is max_threshold minus the speed, clamped to min_threshold;
// a swipe fires when sum_x^2 + sum_y^2 exceeds threshold^2 and the tick
// count since the last swipe exceeds cooldown_ms. A fired swipe is one beat
// on out_ch with direction and finger count, held in an output register so
// the next event can be taken while it waits; the block stalls only when a
// second swipe is ready before the first was taken. Configuration writes
// are registered and should be made while idle.

module swipe_gesture_detector_unit import swp_pkg::*; #(
  parameter int DELTA_WIDTH = 16,
  parameter int SUM_WIDTH   = 24
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  swp_in_if.sink                 in_ch,
  swp_out_if.source              out_ch,
  input  wire logic              cfg_we,
  input  wire logic [CFGI_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_wdata
);

  localparam int DW  = DELTA_WIDTH;
  localparam int SW  = SUM_WIDTH;
  localparam int MW0 = (SW > DW) ? SW : DW;
  localparam int MW  = (MW0 > THR_W) ? MW0 : THR_W;   // multiplier operand
  localparam int PW  = 2 * MW;                         // product / sums of squares
  localparam int VW  = 2 * DW;                         // root radicand
  localparam int RW  = DW;                             // root result
  localparam int EW  = MW0 + 1;                        // sum adder
  localparam int TW0 = (RW > THR_W) ? RW : THR_W;
  localparam int TW  = TW0 + 2;                        // threshold difference

  localparam int          STW      = 4;
  localparam logic [STW-1:0] ST_IDLE  = 4'd0;
  localparam logic [STW-1:0] ST_MDX   = 4'd1;
  localparam logic [STW-1:0] ST_MDY   = 4'd2;
  localparam logic [STW-1:0] ST_SUMV  = 4'd3;
  localparam logic [STW-1:0] ST_ROOT  = 4'd4;
  localparam logic [STW-1:0] ST_THR   = 4'd5;
  localparam logic [STW-1:0] ST_MTHR  = 4'd6;
  localparam logic [STW-1:0] ST_MSX   = 4'd7;
  localparam logic [STW-1:0] ST_MSY   = 4'd8;
  localparam logic [STW-1:0] ST_DECIDE = 4'd9;

  // configuration
  logic [THR_W-1:0] max_thr_r, min_thr_r;
  logic [CD_W-1:0]  cooldown_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_thr_r  <= MAX_THR_RST;
      min_thr_r  <= MIN_THR_RST;
      cooldown_r <= COOLDOWN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_THR:  max_thr_r  <= cfg_wdata[THR_W-1:0];
        CFG_MIN_THR:  min_thr_r  <= cfg_wdata[THR_W-1:0];
        CFG_COOLDOWN: cooldown_r <= cfg_wdata[CD_W-1:0];
        default: ;
      endcase
    end
  end

  // saturating add of a delta into a running sum
  function automatic logic signed [SW-1:0] sat_add(logic signed [SW-1:0] s,
                                                    logic signed [DW-1:0] d);
    logic signed [EW-1:0] t;
    logic signed [EW-1:0] hi;
    logic signed [EW-1:0] lo;
    t  = EW'(s) + EW'(d);
    hi = EW'({1'b0, {(SW-1){1'b1}}});
    lo = -hi - EW'(1);
    if (t > hi)      sat_add = hi[SW-1:0];
    else if (t < lo) sat_add = lo[SW-1:0];
    else             sat_add = t[SW-1:0];
  endfunction

  function automatic logic [MW-1:0] mag_sum(logic signed [SW-1:0] s);
    logic [SW-1:0] m;
    m = s[SW-1] ? (~s + 1'b1) : s;
    mag_sum = MW'(m);
  endfunction

  function automatic logic [MW-1:0] mag_delta(logic signed [DW-1:0] d);
    logic [DW-1:0] m;
    m = d[DW-1] ? (~d + 1'b1) : d;
    mag_delta = MW'(m);
  endfunction

  logic [STW-1:0]        state_r, state_nxt;
  logic signed [SW-1:0]  sum_x_r, sum_x_nxt, sum_y_r, sum_y_nxt;
  logic [MS_W-1:0]       ms_r, ms_nxt;
  logic [MW-1:0]         mag_dx_r, mag_dy_r;
  logic [FING_W-1:0]     fing_r;
  logic [PW-1:0]         prod_r, prod_nxt;
  logic [PW-1:0]         acc_r, acc_nxt;
  logic [PW-1:0]         thr2_r, thr2_nxt;
  logic [THR_W-1:0]      thr_r, thr_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [DIR_W-1:0]      dir_r, dir_nxt;
  logic [FING_W-1:0]     out_fing_r, out_fing_nxt;

  logic                  in_fire;
  logic [MW-1:0]         mul_a;
  logic [PW-1:0]         radicand;
  logic                  root_start;
  root_stat_t            root_st;
  logic [RW-1:0]         root;
  logic [MW-1:0]         mag_sx, mag_sy;
  logic [PW-1:0]         dist2;
  logic                  fire;
  logic signed [TW-1:0]  thr_diff;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign mag_sx = mag_sum(sum_x_r);
  assign mag_sy = mag_sum(sum_y_r);

  // shared multiplier: operand picked by sequencer step, squared
  always_comb begin
    case (state_r)
      ST_MDX:  mul_a = mag_dx_r;
      ST_MDY:  mul_a = mag_dy_r;
      ST_MTHR: mul_a = MW'(thr_r);
      ST_MSX:  mul_a = mag_sx;
      default: mul_a = mag_sy;
    endcase
  end
  assign prod_nxt = mul_a * mul_a;

  assign radicand   = acc_r + prod_r;
  assign root_start = (state_r == ST_SUMV);

  swp_root_unit #(.VW(VW)) u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_start),
    .value (radicand[VW-1:0]),
    .stat  (root_st),
    .root  (root)
  );

  assign thr_diff = $signed(TW'(max_thr_r)) - $signed(TW'(root));
  assign dist2    = acc_r + prod_r;
  assign fire     = (dist2 > thr2_r) && (ms_r > MS_W'(cooldown_r));

  always_comb begin
    state_nxt     = state_r;
    sum_x_nxt     = sum_x_r;
    sum_y_nxt     = sum_y_r;
    ms_nxt        = ms_r;
    acc_nxt       = acc_r;
    thr2_nxt      = thr2_r;
    thr_nxt       = thr_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    dir_nxt       = dir_r;
    out_fing_nxt  = out_fing_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_ch.kind)
            KIND_BEGIN: begin
              sum_x_nxt = '0;
              sum_y_nxt = '0;
            end
            KIND_TICK: begin
              if (ms_r != {MS_W{1'b1}}) ms_nxt = ms_r + 1'b1;
            end
            KIND_UPDATE: begin
              sum_x_nxt = sat_add(sum_x_r, in_ch.delta_x);
              sum_y_nxt = sat_add(sum_y_r, in_ch.delta_y);
              state_nxt = ST_MDX;
            end
            default: ;   // end of swipe: nothing to do
          endcase
        end
      end
      ST_MDX:  state_nxt = ST_MDY;
      ST_MDY: begin
        acc_nxt   = prod_r;
        state_nxt = ST_SUMV;
      end
      ST_SUMV: state_nxt = ST_ROOT;
      ST_ROOT: begin
        if (root_st.done) state_nxt = ST_THR;
      end
      ST_THR: begin
        if (thr_diff < $signed(TW'(min_thr_r))) thr_nxt = min_thr_r;
        else                                     thr_nxt = thr_diff[THR_W-1:0];
        state_nxt = ST_MTHR;
      end
      ST_MTHR: state_nxt = ST_MSX;
      ST_MSX: begin
        thr2_nxt  = prod_r;
        state_nxt = ST_MSY;
      end
      ST_MSY: begin
        acc_nxt   = prod_r;
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!fire) begin
          state_nxt = ST_IDLE;
        end else if (!(out_valid_r && !out_ch.ready)) begin
          out_valid_nxt = 1'b1;
          out_fing_nxt  = fing_r;
          if (mag_sx > mag_sy) dir_nxt = (sum_x_r > 0) ? DIR_RIGHT : DIR_LEFT;
          else                 dir_nxt = (sum_y_r > 0) ? DIR_DOWN : DIR_UP;
          sum_x_nxt = '0;
          sum_y_nxt = '0;
          ms_nxt    = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      ms_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_x_r     <= sum_x_nxt;
      sum_y_r     <= sum_y_nxt;
      ms_r        <= ms_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_fire) begin
      mag_dx_r <= mag_delta(in_ch.delta_x);
      mag_dy_r <= mag_delta(in_ch.delta_y);
      fing_r   <= in_ch.finger_count;
    end
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    thr2_r     <= thr2_nxt;
    thr_r      <= thr_nxt;
    dir_r      <= dir_nxt;
    out_fing_r <= out_fing_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.direction = dir_r;
  assign out_ch.fingers   = out_fing_r;

  a_emit_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DECIDE)
    else $error("result raised outside the decide step");
  a_trigger_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECIDE && fire && !(out_valid_r && !out_ch.ready))
      |=> (ms_r == '0 && sum_x_r == '0 && sum_y_r == '0))
    else $error("trigger did not clear sums and timer");
  a_root_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    root_st.done |-> state_r == ST_ROOT)
    else $error("root finished outside its step");
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    root_st.busy |-> !in_ch.ready)
    else $error("input ready while root unit busy");

endmodule

`default_nettype wire

// ===== sim/tb_swipe_gesture_detector_unit.sv =====
// Self-checking testbench for swipe_gesture_detector_unit: directed and random
// event beats, a per-beat gesture predictor and an in-order result scoreboard.
// Depends on swp_pkg, swp_if and the RTL of the detector.

module tb_swipe_gesture_detector_unit;
  import swp_pkg::*;

  localparam int DELTA_W       = 16;
  localparam int SUM_W         = 24;
  localparam int DELTA_MAX     = (1 << (DELTA_W - 1)) - 1;
  localparam int DELTA_MIN     = -(1 << (DELTA_W - 1));
  // An update keeps the block busy through all its steps; wait long enough
  // before touching the registers that an update with no swipe has drained.
  localparam int SETTLE_CYCLES = 2 * (DELTA_W + 9);
  localparam int STALL_LIMIT   = 2000;
  // cooldown for the boundary check at the end of the run
  localparam int CD_EDGE       = 40;
  // register index that decodes to nothing
  localparam logic [CFGI_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [DIR_W-1:0]  direction;
    logic [FING_W-1:0] fingers;
  } swipe_t;

  // Gesture predictor plus the queue of swipes still owed by the block.
  class swipe_scoreboard;
    logic [THR_W-1:0] max_thr;
    logic [THR_W-1:0] min_thr;
    logic [CD_W-1:0]  cooldown;
    longint           sum_x;
    longint           sum_y;
    logic [MS_W-1:0]  ms_count;
    swipe_t           swipe_q[$];
    int               errors;

    function new();
      max_thr  = MAX_THR_RST;
      min_thr  = MIN_THR_RST;
      cooldown = COOLDOWN_RST;
      sum_x    = 0;
      sum_y    = 0;
      ms_count = '0;
      errors   = 0;
    endfunction

    function int pending();
      return swipe_q.size();
    endfunction

    function void write_reg(logic [CFGI_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_MAX_THR:  max_thr = data[THR_W-1:0];
        CFG_MIN_THR:  min_thr = data[THR_W-1:0];
        CFG_COOLDOWN: cooldown = data[CD_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp_sum(longint v);
      longint hi;
      hi = (longint'(1) << (SUM_W - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    // floor of the square root, one result bit per pass
    function longint floor_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = longint'(1) << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return longint'(r);
    endfunction

    function void note_event(logic [KIND_W-1:0] kind, logic signed [DELTA_W-1:0] dx,
                             logic signed [DELTA_W-1:0] dy, logic [FING_W-1:0] fing);
      longint dxl;
      longint dyl;
      longint speed;
      longint thr;
      longint ax;
      longint ay;
      swipe_t s;
      case (kind)
        KIND_BEGIN: begin
          sum_x = 0;
          sum_y = 0;
        end
        KIND_TICK: begin
          if (ms_count != '1) ms_count = ms_count + 1'b1;
        end
        KIND_UPDATE: begin
          dxl   = longint'(dx);
          dyl   = longint'(dy);
          sum_x = clamp_sum(sum_x + dxl);
          sum_y = clamp_sum(sum_y + dyl);
          speed = floor_sqrt(longint'(dxl * dxl + dyl * dyl));
          thr   = longint'(max_thr) - speed;
          if (thr < longint'(min_thr)) thr = longint'(min_thr);
          ax = (sum_x < 0) ? -sum_x : sum_x;
          ay = (sum_y < 0) ? -sum_y : sum_y;
          if ((ax * ax + ay * ay > thr * thr) && (ms_count > MS_W'(cooldown))) begin
            if (ax > ay) s.direction = (sum_x > 0) ? DIR_RIGHT : DIR_LEFT;
            else         s.direction = (sum_y > 0) ? DIR_DOWN : DIR_UP;
            s.fingers = fing;
            swipe_q.push_back(s);
            sum_x    = 0;
            sum_y    = 0;
            ms_count = '0;
          end
        end
        default: ;  // end of gesture: nothing to do
      endcase
    endfunction

    function void check_swipe(logic [DIR_W-1:0] dir, logic [FING_W-1:0] fing);
      swipe_t want;
      if (swipe_q.size() == 0) begin
        $display("%0t: unexpected swipe, expected none, actual direction %0d fingers %0d",
                 $time, dir, fing);
        errors++;
      end else begin
        want = swipe_q.pop_front();
        if (want.direction !== dir) begin
          $display("%0t: direction mismatch, expected %0d actual %0d",
                   $time, want.direction, dir);
          errors++;
        end
        if (want.fingers !== fing) begin
          $display("%0t: fingers mismatch, expected %0d actual %0d",
                   $time, want.fingers, fing);
          errors++;
        end
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [CFGI_W-1:0]  cfg_index;
  logic [CFG_W-1:0]   cfg_wdata;

  swp_in_if #(.DELTA_WIDTH(DELTA_W)) in_ch();
  swp_out_if                         out_ch();

  swipe_scoreboard sb;
  int              send_idle;      // percent of cycles the event side holds back
  int              recv_idle;      // percent of cycles the result side stalls
  int              stall_cycles = 0;

  swipe_gesture_detector_unit #(
    .DELTA_WIDTH(DELTA_W),
    .SUM_WIDTH  (SUM_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: ready toggles at random, held low through reset.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Monitor: everything is sampled at the edge where it takes effect. The
  // result is checked before the event beat of the same edge is predicted,
  // since a swipe can never leave in the cycle its update arrives.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        sb.check_swipe(out_ch.direction, out_ch.fingers);
      end
      if (in_ch.valid && in_ch.ready) begin
        sb.note_event(in_ch.kind, in_ch.delta_x, in_ch.delta_y, in_ch.finger_count);
      end
      if (cfg_we) sb.write_reg(cfg_index, cfg_wdata);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Watchdog: too long without a beat on either channel or a config write means a hang.
  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("** swipe_gesture_detector_unit: FAILED **");
    $finish;
  end

  // One event beat; returns at the edge that accepts it with valid still up,
  // so the next beat can follow back to back.
  task automatic send_event(input logic [KIND_W-1:0] kind,
                            input logic signed [DELTA_W-1:0] dx,
                            input logic signed [DELTA_W-1:0] dy,
                            input logic [FING_W-1:0] fing);
    while ($urandom_range(0, 99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= kind;
    in_ch.delta_x      <= dx;
    in_ch.delta_y      <= dy;
    in_ch.finger_count <= fing;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_update(input int dx, input int dy, input int fing);
    send_event(KIND_UPDATE, DELTA_W'(dx), DELTA_W'(dy), FING_W'(fing));
  endtask

  // begin, end and tick carry junk in the unused fields
  task automatic send_filler(input logic [KIND_W-1:0] kind);
    send_event(kind, DELTA_W'($urandom), DELTA_W'($urandom), FING_W'($urandom));
  endtask

  // Drop valid, wait for every owed swipe, then let a last update drain.
  // One edge first so the monitor has noted the final beat.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // All registers back to back, then a write to the unused index. Upper
  // data bits of the cooldown write carry junk that must be dropped.
  task automatic program_regs(input logic [THR_W-1:0] max_v, input logic [THR_W-1:0] min_v,
                              input logic [CD_W-1:0] cd_v);
    logic [CFG_W-CD_W-1:0] junk;
    junk = (CFG_W - CD_W)'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAX_THR;
    cfg_wdata <= max_v;
    @(posedge clk);
    cfg_index <= CFG_MIN_THR;
    cfg_wdata <= min_v;
    @(posedge clk);
    cfg_index <= CFG_COOLDOWN;
    cfg_wdata <= {junk, cd_v};
    @(posedge clk);
    cfg_index <= CFG_UNUSED;
    cfg_wdata <= CFG_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Motion of one update; the scale picks small, moderate, any, or extreme.
  function automatic int rand_delta(int scale);
    if (scale < 4) return int'($urandom_range(0, 512)) - 256;
    if (scale < 7) return int'($urandom_range(0, 8192)) - 4096;
    if (scale < 9) return int'($urandom);
    case ($urandom_range(0, 3))
      0: return DELTA_MIN;
      1: return DELTA_MAX;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  // Mostly whole gestures (begin, updates with ticks between, end), the rest
  // stray beats of any kind and gestures with a missing begin or end.
  task automatic run_random(input int n_items);
    int                sent;
    int                scale;
    logic [KIND_W-1:0] kind;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 10) begin
        kind = KIND_W'($urandom);
        send_filler(kind);
        if (kind == KIND_UPDATE) begin
          send_update(rand_delta(8), rand_delta(8), $urandom_range(0, 7));
        end
        if (kind != KIND_END) sent++;
      end else begin
        scale = $urandom_range(0, 9);
        if ($urandom_range(0, 9) != 0) begin
          send_filler(KIND_BEGIN);
          sent++;
        end
        repeat ($urandom_range(1, 16)) begin
          repeat ($urandom_range(0, 3)) begin
            send_filler(KIND_TICK);
            sent++;
          end
          send_update(rand_delta(scale), rand_delta(scale), $urandom_range(0, 7));
          sent++;
        end
        if ($urandom_range(0, 3) != 0) send_filler(KIND_END);
      end
    end
  endtask

  initial begin
    sb                 = new();
    send_idle          = 28;
    recv_idle          = 45;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.kind         <= KIND_BEGIN;
    in_ch.delta_x      <= '0;
    in_ch.delta_y      <= '0;
    in_ch.finger_count <= '0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_MAX_THR;
    cfg_wdata          <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: the timer starts at zero, so nothing may fire even
    // for the largest motion.
    send_filler(KIND_BEGIN);
    send_update(DELTA_MAX, DELTA_MIN, 7);
    send_filler(KIND_END);
    send_filler(KIND_TICK);
    send_update(DELTA_MIN, DELTA_MAX, 0);
    send_filler(KIND_BEGIN);

    // No cooldown: one tick arms the next swipe. Walk all four directions,
    // a swipe that waits on the timer, and a tie that resolves to up.
    settle();
    program_regs(20'd1600, 20'd480, 16'd0);
    send_filler(KIND_TICK);
    send_update(1600, 0, 1);
    send_update(-3000, 0, 2);
    send_filler(KIND_TICK);
    send_update(0, 0, 5);
    send_filler(KIND_BEGIN);
    send_filler(KIND_TICK);
    send_update(0, DELTA_MIN, 6);
    send_filler(KIND_TICK);
    send_update(0, 2000, 0);
    send_filler(KIND_BEGIN);
    send_filler(KIND_TICK);
    send_update(500, -500, 3);
    send_update(500, -500, 3);

    // Zero threshold: zero sums stay quiet, the smallest motion fires.
    settle();
    program_regs('0, '0, '0);
    send_filler(KIND_TICK);
    send_update(0, 0, 7);
    send_update(1, 1, 4);

    // Random gestures over six settings and three idle mixes.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 2) begin
        send_idle = 28;
        recv_idle = 45;
      end else if (ph < 4) begin
        send_idle = 45;
        recv_idle = 28;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      settle();
      case (ph)
        0: program_regs(20'd1600, 20'd480, 16'd2);
        1: program_regs('0, '0, '0);
        2: program_regs(THR_W'($urandom_range(200, 3000)), THR_W'($urandom_range(0, 800)),
                        CD_W'($urandom_range(0, 6)));
        3: program_regs('1, '0, 16'd1);
        4: program_regs(20'd100, 20'd2000, 16'd0);  // floor above the ceiling
        default: program_regs(THR_W'($urandom_range(0, 2000)), THR_W'($urandom_range(0, 2000)),
                              CD_W'($urandom_range(0, 3)));
      endcase
      if (ph == 1) begin
        // hold the event side until every swipe has been taken
        run_random(70);
        settle();
        run_random(80);
      end else begin
        run_random(150);
      end
    end

    // Push both sums into saturation under the largest thresholds while the
    // cooldown blocks any swipe, then release it: the clipped sums still
    // beat the largest threshold.
    settle();
    program_regs('1, '1, '1);
    send_filler(KIND_BEGIN);
    repeat (300) begin
      send_update(DELTA_MAX - int'($urandom_range(0, 63)), DELTA_MIN + int'($urandom_range(0, 63)),
                  $urandom_range(0, 7));
    end
    settle();
    program_regs('1, '1, '0);
    send_filler(KIND_TICK);
    send_update(0, 0, 2);

    // Cooldown edge: at exactly the limit nothing fires, one tick more
    // and the same motion does.
    settle();
    program_regs('0, '0, CD_W'(CD_EDGE));
    repeat (CD_EDGE) send_filler(KIND_TICK);
    send_update(16, 0, 3);
    send_filler(KIND_TICK);
    send_update(16, 0, 6);

    settle();
    if (sb.errors == 0) begin
      $display("** swipe_gesture_detector_unit: PASSED **");
    end else begin
      $display("** swipe_gesture_detector_unit: FAILED **");
    end
    $finish;
  end

endmodule
